### hdl/prvc_pkg.sv
package prvc_pkg;

	localparam int ADDR_W  = 64;
	localparam int CNT_W   = 32;
	localparam int SHIFT_W = 5;
	localparam int KIND_W  = 2;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

	localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

	localparam logic REQ_NEW    = 1'b0;
	localparam logic REQ_ANSWER = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEC,
		ST_LOOK,
		ST_ADV
	} state_t;

	typedef enum logic {
		AU_LAST,
		AU_NEXT
	} au_mode_t;

endpackage

### hdl/prvc_au.sv
module prvc_au (
	input  logic [prvc_pkg::ADDR_W-1:0]  a,
	input  logic [prvc_pkg::CNT_W-1:0]   cnt,
	input  prvc_pkg::au_mode_t           mode,
	input  logic [prvc_pkg::SHIFT_W-1:0] shift,
	output logic [prvc_pkg::ADDR_W-1:0]  sum,
	output logic                         carry,
	output logic [prvc_pkg::ADDR_W-1:0]  page_a,
	output logic [prvc_pkg::ADDR_W-1:0]  page_sum
);

	logic [prvc_pkg::ADDR_W-1:0] size;
	logic [prvc_pkg::ADDR_W-1:0] pmask;
	logic [prvc_pkg::ADDR_W-1:0] op_x;
	logic [prvc_pkg::ADDR_W-1:0] op_y;

	assign size   = {{(prvc_pkg::ADDR_W-1){1'b0}}, 1'b1} << shift;
	assign pmask  = ~(size - {{(prvc_pkg::ADDR_W-1){1'b0}}, 1'b1});
	assign page_a = a & pmask;

	// last byte of a range, or start of the page after a
	always_comb begin
		case (mode)
			prvc_pkg::AU_NEXT: begin
				op_x = page_a;
				op_y = size;
			end
			default: begin
				op_x = a;
				op_y = {{(prvc_pkg::ADDR_W-prvc_pkg::CNT_W){1'b0}},
					cnt - {{(prvc_pkg::CNT_W-1){1'b0}}, 1'b1}};
			end
		endcase
	end

	assign {carry, sum} = {1'b0, op_x} + {1'b0, op_y};
	assign page_sum     = sum & pmask;

endmodule

### hdl/prvc_cache.sv
module prvc_cache #(
	parameter int CACHE_SLOTS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [prvc_pkg::ADDR_W-1:0] look_page,
	output logic                        hit,
	input  logic                        ins_en,
	input  logic [prvc_pkg::ADDR_W-1:0] ins_page
);

	localparam int IW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int FW = $clog2(CACHE_SLOTS + 1);

	logic [prvc_pkg::ADDR_W-1:0] slot_q [CACHE_SLOTS];
	logic [FW-1:0]               fill_q;
	logic [IW-1:0]               victim_q;
	logic                        full;
	logic [IW-1:0]               wr_idx;

	// slots fill in order from zero and never empty again, so the fill count
	// is the write index (the first free slot) until the cache is full, then the victim pointer
	assign full   = (fill_q == FW'(CACHE_SLOTS));
	assign wr_idx = full ? victim_q : fill_q[IW-1:0];

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			if ((FW'(i) < fill_q) && (slot_q[i] == look_page)) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			victim_q <= '0;
		end else if (ins_en) begin
			if (!full) begin
				fill_q <= fill_q + {{(FW-1){1'b0}}, 1'b1};
			end else if (victim_q == IW'(CACHE_SLOTS - 1)) begin
				victim_q <= '0;
			end else begin
				victim_q <= victim_q + {{(IW-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			slot_q[wr_idx] <= ins_page;
		end
	end

endmodule

### hdl/page_range_validity_checker.sv
// Page range validity checker.
// Command channel: drive req_type, start_addr, byte_count and page_readable
// with start high; the transaction is taken at a clock edge where busy is low.
// req_type new asks whether a byte range is readable; req_type answer gives
// the readable answer for the page last asked for by a probe result.
// Every transaction gives exactly one result, shown on result_kind, range_valid
// and probe_page for one cycle with done high. The receiver cannot stall:
// the result is taken in that cycle, and busy is already low then.
// Errors, zero-length ranges, unreadable answers and the first checks are
// decided in the decode state, and that result is registered onto done.
// A walk then visits each cached page with a cache lookup, then one pass
// through the shared page adder, and a readable answer first steps past the
// answered page in the adder; one transaction is in flight at a time.
// After reset the page cache is empty, no probe is pending and page_shift
// is 12. page_shift is written on the cfg channel (always ready) and should
// only change while no transaction is in progress.
module page_range_validity_checker #(
	parameter int CACHE_SLOTS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [prvc_pkg::ADDR_W-1:0]  start_addr,
	input  logic [prvc_pkg::CNT_W-1:0]   byte_count,
	input  logic                         page_readable,
	output logic                         done,
	output logic [prvc_pkg::KIND_W-1:0]  result_kind,
	output logic                         range_valid,
	output logic [prvc_pkg::ADDR_W-1:0]  probe_page,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [prvc_pkg::SHIFT_W-1:0] cfg_data
);

	localparam int FW = $clog2(CACHE_SLOTS + 1);

	prvc_pkg::state_t state_q, state_d;

	logic [prvc_pkg::SHIFT_W-1:0] shift_q;
	logic                         req_q;
	logic [prvc_pkg::ADDR_W-1:0]  addr_q;
	logic [prvc_pkg::CNT_W-1:0]   cnt_q;
	logic                         rd_q;

	logic                        pending_q, pending_d;
	logic [prvc_pkg::ADDR_W-1:0] walk_q, walk_d;
	logic [prvc_pkg::ADDR_W-1:0] final_q, final_d;
	logic [FW-1:0]               iter_q, iter_d;
	logic                        ans_q, ans_d;

	logic                        done_q, done_d;
	logic [prvc_pkg::KIND_W-1:0] kind_q, kind_d;
	logic                        valid_q, valid_d;
	logic [prvc_pkg::ADDR_W-1:0] page_q, page_d;

	logic                        accept;
	prvc_pkg::au_mode_t          au_mode;
	logic [prvc_pkg::ADDR_W-1:0] au_a;
	logic [prvc_pkg::ADDR_W-1:0] au_sum;
	logic                        au_carry;
	logic [prvc_pkg::ADDR_W-1:0] au_page_a;
	logic [prvc_pkg::ADDR_W-1:0] au_page_sum;
	logic                        hit;
	logic                        ins_en;

	assign busy      = (state_q != prvc_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done        = done_q;
	assign result_kind = kind_q;
	assign range_valid = valid_q;
	assign probe_page  = page_q;

	assign au_mode = (state_q == prvc_pkg::ST_ADV) ? prvc_pkg::AU_NEXT : prvc_pkg::AU_LAST;
	assign au_a    = (state_q == prvc_pkg::ST_ADV) ? walk_q : addr_q;

	prvc_au u_au (
		.a        (au_a),
		.cnt      (cnt_q),
		.mode     (au_mode),
		.shift    (shift_q),
		.sum      (au_sum),
		.carry    (au_carry),
		.page_a   (au_page_a),
		.page_sum (au_page_sum)
	);

	prvc_cache #(
		.CACHE_SLOTS (CACHE_SLOTS)
	) u_cache (
		.clk       (clk),
		.arst_n    (arst_n),
		.look_page (walk_q),
		.hit       (hit),
		.ins_en    (ins_en),
		.ins_page  (walk_q)
	);

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		walk_d    = walk_q;
		final_d   = final_q;
		iter_d    = iter_q;
		ans_d     = ans_q;
		done_d    = 1'b0;
		kind_d    = prvc_pkg::KIND_VERDICT;
		valid_d   = 1'b0;
		page_d    = '0;
		ins_en    = 1'b0;

		case (state_q)
			prvc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = prvc_pkg::ST_DEC;
				end
			end

			prvc_pkg::ST_DEC: begin
				state_d = prvc_pkg::ST_IDLE;
				if (req_q == prvc_pkg::REQ_NEW) begin
					done_d = 1'b1;
					if (pending_q) begin
						kind_d = prvc_pkg::KIND_ERROR;
					end else if (cnt_q == '0) begin
						valid_d = 1'b1;
					end else if (au_page_a == '0 || au_carry) begin
						valid_d = 1'b0;
					end else begin
						// no result yet: start the walk
						done_d  = 1'b0;
						walk_d  = au_page_a;
						final_d = au_page_sum;
						iter_d  = '0;
						ans_d   = 1'b0;
						state_d = prvc_pkg::ST_LOOK;
					end
				end else begin
					if (!pending_q) begin
						done_d = 1'b1;
						kind_d = prvc_pkg::KIND_ERROR;
					end else if (!rd_q) begin
						pending_d = 1'b0;
						done_d    = 1'b1;
					end else begin
						pending_d = 1'b0;
						ins_en    = 1'b1;
						ans_d     = 1'b1;
						state_d   = prvc_pkg::ST_ADV;
					end
				end
			end

			prvc_pkg::ST_LOOK: begin
				if (hit) begin
					state_d = prvc_pkg::ST_ADV;
				end else begin
					pending_d = 1'b1;
					done_d    = 1'b1;
					kind_d    = prvc_pkg::KIND_PROBE;
					page_d    = walk_q;
					state_d   = prvc_pkg::ST_IDLE;
				end
			end

			prvc_pkg::ST_ADV: begin
				if (walk_q >= final_q || au_carry) begin
					done_d  = 1'b1;
					valid_d = 1'b1;
					ans_d   = 1'b0;
					state_d = prvc_pkg::ST_IDLE;
				end else begin
					walk_d = au_sum;
					if (ans_q) begin
						ans_d   = 1'b0;
						iter_d  = '0;
						state_d = prvc_pkg::ST_LOOK;
					end else if (iter_q == FW'(CACHE_SLOTS)) begin
						// walk budget spent: probe the next page regardless
						pending_d = 1'b1;
						done_d    = 1'b1;
						kind_d    = prvc_pkg::KIND_PROBE;
						page_d    = au_sum;
						state_d   = prvc_pkg::ST_IDLE;
					end else begin
						iter_d  = iter_q + {{(FW-1){1'b0}}, 1'b1};
						state_d = prvc_pkg::ST_LOOK;
					end
				end
			end

			default: begin
				state_d = prvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= prvc_pkg::ST_IDLE;
			shift_q   <= prvc_pkg::SHIFT_RESET;
			pending_q <= 1'b0;
			walk_q    <= '0;
			final_q   <= '0;
			iter_q    <= '0;
			ans_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
			walk_q    <= walk_d;
			final_q   <= final_d;
			iter_q    <= iter_d;
			ans_q     <= ans_d;
			done_q    <= done_d;
			if (cfg_valid && cfg_ready) begin
				shift_q <= cfg_data;
			end
		end
	end

	// capture the transaction and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			addr_q <= start_addr;
			cnt_q  <= byte_count;
			rd_q   <= page_readable;
		end
		kind_q  <= kind_d;
		valid_q <= valid_d;
		page_q  <= page_d;
	end

endmodule
